FILE: rtl/tma_pkg.sv
// Shared constants, types and register codes of the tile mosaic averaging block.
`default_nettype none
package tma_pkg;

  // Frame and tile limits
  localparam int MAX_WIDTH    = 4096;
  localparam int LINE_LIMIT   = 4096;
  localparam int MAX_TILE     = 64;
  localparam int CHANNEL_BITS = 8;

  // Derived widths
  localparam int ADDR_W  = 12;              // sum memory address, one entry per column
  localparam int SUM_W   = 20;              // 64 * 64 * 255 fits
  localparam int REM_W   = SUM_W + 1;       // sum plus rounding half
  localparam int N_W     = 13;              // pixels per tile, up to 4096
  localparam int DSR_W   = N_W + CHANNEL_BITS - 1;
  localparam int CNT_W   = 3;               // divider step counter

  localparam logic [6:0]       TILE_LIMIT  = 7'd64;
  localparam logic [12:0]      WIDTH_LIMIT = 13'd4096;
  localparam logic [12:0]      HEIGHT_LIMIT = 13'd4096;
  localparam logic [CNT_W-1:0] LAST_STEP   = 3'd7;

  // Register indexes on the configuration port
  typedef enum logic [1:0] {
    REG_TILE   = 2'd0,
    REG_WIDTH  = 2'd1,
    REG_HEIGHT = 2'd2,
    REG_NONE   = 2'd3
  } reg_idx_t;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_ADD  = 2'd1,
    ST_DIV  = 2'd2,
    ST_EMIT = 2'd3
  } state_t;

  // Control word broadcast to every channel lane
  typedef struct packed {
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic              first;
    logic              div_load;
    logic              div_step;
    logic [N_W-1:0]    n;
  } lane_ctl_t;

endpackage
`default_nettype wire

FILE: rtl/tma_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module tma_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

FILE: rtl/tma_lane.sv
// One color lane: per-column tile sum memory, accumulator and rounding divider.
`default_nettype none
module tma_lane (
  input  wire logic                            clk,
  input  wire tma_pkg::lane_ctl_t              ctl,
  input  wire logic [tma_pkg::CHANNEL_BITS-1:0] pix,
  output logic      [tma_pkg::CHANNEL_BITS-1:0] mean
);

  logic [tma_pkg::SUM_W-1:0] rd_data;
  logic [tma_pkg::SUM_W-1:0] sum_next;
  logic [tma_pkg::REM_W-1:0] rem;
  logic [tma_pkg::DSR_W-1:0] dsr;
  logic [tma_pkg::REM_W-1:0] trial;

  tma_ram #(
    .WIDTH(tma_pkg::SUM_W),
    .DEPTH(tma_pkg::MAX_WIDTH)
  ) u_sums (
    .clk     (clk),
    .wr_en   (ctl.wr_en),
    .wr_addr (ctl.wr_addr),
    .wr_data (sum_next),
    .rd_en   (ctl.rd_en),
    .rd_addr (ctl.rd_addr),
    .rd_data (rd_data)
  );

  // Start a fresh sum on the first pixel of a tile, else accumulate
  always_comb begin
    if (ctl.first) begin
      sum_next = tma_pkg::SUM_W'(pix);
    end else begin
      sum_next = rd_data + tma_pkg::SUM_W'(pix);
    end
  end

  assign trial = rem - tma_pkg::REM_W'(dsr);

  // Restoring division, one quotient bit per step
  always_ff @(posedge clk) begin
    if (ctl.div_load) begin
      rem  <= tma_pkg::REM_W'(sum_next) + tma_pkg::REM_W'(ctl.n >> 1);
      dsr  <= {ctl.n, {(tma_pkg::CHANNEL_BITS-1){1'b0}}};
      mean <= '0;
    end else if (ctl.div_step) begin
      if (rem >= tma_pkg::REM_W'(dsr)) begin
        rem  <= trial;
        mean <= {mean[tma_pkg::CHANNEL_BITS-2:0], 1'b1};
      end else begin
        mean <= {mean[tma_pkg::CHANNEL_BITS-2:0], 1'b0};
      end
      dsr <= dsr >> 1;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/tile_mosaic_average_core.sv
// Top level: raster tracking, lane control and the merged tile result register.
//
//  channel  | handshake              | payload
//  ---------+------------------------+-------------------------------------------
//  pixel    | pix_valid / pix_ready  | red_in, green_in, blue_in
//  tile     | tile_valid / tile_ready| *_mean, tile_top/left/rows/cols, size_error
//  config   | APB psel/penable       | paddr, pwdata, prdata
//
// A pixel is accepted and reads the column sum memory in ST_IDLE, then adds and
// writes back in ST_ADD. A pixel that closes a tile runs 8 divider steps and loads
// the result register; one shared sequencer drives all lanes. A rejected frame's
// pixel is taken without accumulation; the error word loads the result register.
// Reset (rst, synchronous) restores control state and the raster position; the
// sum memories need no clearing. A stalled tile result holds only the sequencer
// when the next result is ready; pixels are taken while a result waits.
`default_nettype none
module tile_mosaic_average_core (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  input  wire logic        pix_valid,
  output logic             pix_ready,
  input  wire logic [7:0]  red_in,
  input  wire logic [7:0]  green_in,
  input  wire logic [7:0]  blue_in,
  output logic             tile_valid,
  input  wire logic        tile_ready,
  output logic      [7:0]  red_mean,
  output logic      [7:0]  green_mean,
  output logic      [7:0]  blue_mean,
  output logic      [11:0] tile_top,
  output logic      [11:0] tile_left,
  output logic      [6:0]  tile_rows,
  output logic      [6:0]  tile_cols,
  output logic             size_error
);

  logic [6:0]  cfg_tile;
  logic [12:0] cfg_width;
  logic [12:0] cfg_height;
  logic [6:0]  lat_tile;
  logic [12:0] lat_width;
  logic [12:0] lat_height;
  logic [11:0] line_index;
  logic [11:0] column_index;
  logic [5:0]  row_in_tile;
  logic [5:0]  col_in_tile;
  logic        frame_rejected;

  tma_pkg::state_t state, state_next;
  logic [tma_pkg::CNT_W-1:0] div_cnt;

  logic [11:0] res_top;
  logic [11:0] res_left;
  logic [6:0]  res_rows;
  logic [6:0]  res_cols;
  logic [tma_pkg::N_W-1:0] res_n;
  logic        res_first;
  logic        res_done;
  logic        res_err;
  logic [tma_pkg::CHANNEL_BITS-1:0] pix_red;
  logic [tma_pkg::CHANNEL_BITS-1:0] pix_green;
  logic [tma_pkg::CHANNEL_BITS-1:0] pix_blue;

  logic        cfg_wr;
  logic        pix_acc;
  logic        out_load;
  logic        frame_start;
  logic        bad;
  logic [12:0] width_clamp;
  logic [12:0] height_clamp;
  logic [6:0]  cur_tile;
  logic [12:0] cur_width;
  logic [12:0] cur_height;
  logic        eol;
  logic        last_line;
  logic        eof;
  logic        tcol_end;
  logic        trow_end;
  logic        rej;
  logic [6:0]  rows_now;
  logic [6:0]  cols_now;
  logic [13:0] n_prod;

  tma_pkg::lane_ctl_t ctl;
  logic [tma_pkg::CHANNEL_BITS-1:0] mean_r;
  logic [tma_pkg::CHANNEL_BITS-1:0] mean_g;
  logic [tma_pkg::CHANNEL_BITS-1:0] mean_b;

  // Configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_tile   <= 7'd8;
      cfg_width  <= 13'd640;
      cfg_height <= 13'd480;
    end else if (cfg_wr) begin
      unique case (tma_pkg::reg_idx_t'(paddr[3:2]))
        tma_pkg::REG_TILE:   cfg_tile   <= pwdata[6:0];
        tma_pkg::REG_WIDTH:  cfg_width  <= pwdata[12:0];
        tma_pkg::REG_HEIGHT: cfg_height <= pwdata[12:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (tma_pkg::reg_idx_t'(paddr[3:2]))
      tma_pkg::REG_TILE:   prdata = 32'(cfg_tile);
      tma_pkg::REG_WIDTH:  prdata = 32'(cfg_width);
      tma_pkg::REG_HEIGHT: prdata = 32'(cfg_height);
      default:             prdata = '0;
    endcase
  end

  // Frame start checks and the geometry in force for this pixel
  assign frame_start = (line_index == '0) && (column_index == '0);
  assign bad = (cfg_tile == '0) || (cfg_tile > tma_pkg::TILE_LIMIT) ||
               (cfg_width == '0) || (cfg_height == '0) ||
               (cfg_width > tma_pkg::WIDTH_LIMIT) || (cfg_height > tma_pkg::HEIGHT_LIMIT) ||
               (13'(cfg_tile) > cfg_width) || (13'(cfg_tile) > cfg_height);
  assign width_clamp  = (cfg_width == '0) ? 13'd1 :
                        ((cfg_width > tma_pkg::WIDTH_LIMIT) ? tma_pkg::WIDTH_LIMIT : cfg_width);
  assign height_clamp = (cfg_height == '0) ? 13'd1 :
                        ((cfg_height > tma_pkg::HEIGHT_LIMIT) ? tma_pkg::HEIGHT_LIMIT
                                                              : cfg_height);
  assign cur_tile   = frame_start ? cfg_tile : lat_tile;
  assign cur_width  = frame_start ? width_clamp : lat_width;
  assign cur_height = frame_start ? height_clamp : lat_height;
  assign rej        = frame_start ? bad : frame_rejected;

  // Raster and tile edges
  assign eol       = (13'(column_index) + 13'd1) >= cur_width;
  assign last_line = (13'(line_index) + 13'd1) >= cur_height;
  assign eof       = eol && last_line;
  assign tcol_end  = eol || ((7'(col_in_tile) + 7'd1) >= cur_tile);
  assign trow_end  = last_line || ((7'(row_in_tile) + 7'd1) >= cur_tile);
  assign rows_now  = 7'(row_in_tile) + 7'd1;
  assign cols_now  = 7'(col_in_tile) + 7'd1;
  assign n_prod    = rows_now * cols_now;

  assign pix_acc  = pix_valid && pix_ready;

  // Advance the raster position and latch the frame geometry
  always_ff @(posedge clk) begin
    if (rst) begin
      line_index     <= '0;
      column_index   <= '0;
      row_in_tile    <= '0;
      col_in_tile    <= '0;
      frame_rejected <= 1'b0;
      lat_tile       <= 7'd8;
      lat_width      <= 13'd640;
      lat_height     <= 13'd480;
    end else if (pix_acc) begin
      if (frame_start) begin
        lat_tile   <= cfg_tile;
        lat_width  <= width_clamp;
        lat_height <= height_clamp;
      end
      if (eol) begin
        column_index <= '0;
        col_in_tile  <= '0;
        if (eof) begin
          line_index     <= '0;
          row_in_tile    <= '0;
          frame_rejected <= 1'b0;
        end else begin
          line_index     <= line_index + 12'd1;
          row_in_tile    <= trow_end ? 6'd0 : row_in_tile + 6'd1;
          frame_rejected <= rej;
        end
      end else begin
        column_index   <= column_index + 12'd1;
        col_in_tile    <= tcol_end ? 6'd0 : col_in_tile + 6'd1;
        frame_rejected <= rej;
      end
    end
  end

  // Capture the tile geometry and the channels of the accepted pixel
  always_ff @(posedge clk) begin
    if (pix_acc) begin
      res_top   <= line_index - 12'(row_in_tile);
      res_left  <= column_index - 12'(col_in_tile);
      res_rows  <= rows_now;
      res_cols  <= cols_now;
      res_n     <= n_prod[tma_pkg::N_W-1:0];
      res_first <= (row_in_tile == '0) && (col_in_tile == '0);
      res_done  <= tcol_end && trow_end && !rej;
      res_err   <= frame_start && bad;
      pix_red   <= red_in;
      pix_green <= green_in;
      pix_blue  <= blue_in;
    end
  end

  // Sequencer state and divider step count
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= tma_pkg::ST_IDLE;
      div_cnt <= '0;
    end else begin
      state <= state_next;
      if (state == tma_pkg::ST_DIV) begin
        div_cnt <= div_cnt + 1'b1;
      end else begin
        div_cnt <= '0;
      end
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      tma_pkg::ST_IDLE: begin
        if (pix_acc) begin
          if (frame_start && bad) begin
            state_next = tma_pkg::ST_EMIT;
          end else if (!rej) begin
            state_next = tma_pkg::ST_ADD;
          end
        end
      end
      tma_pkg::ST_ADD: begin
        state_next = res_done ? tma_pkg::ST_DIV : tma_pkg::ST_IDLE;
      end
      tma_pkg::ST_DIV: begin
        if (div_cnt == tma_pkg::LAST_STEP) begin
          state_next = tma_pkg::ST_EMIT;
        end
      end
      tma_pkg::ST_EMIT: begin
        if (!tile_valid || tile_ready) begin
          state_next = tma_pkg::ST_IDLE;
        end
      end
      default: state_next = tma_pkg::ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    pix_ready    = (state == tma_pkg::ST_IDLE);
    out_load     = (state == tma_pkg::ST_EMIT) && (!tile_valid || tile_ready);
    ctl.rd_en    = pix_valid && (state == tma_pkg::ST_IDLE);
    ctl.rd_addr  = column_index - 12'(col_in_tile);
    ctl.wr_en    = (state == tma_pkg::ST_ADD);
    ctl.wr_addr  = res_left;
    ctl.first    = res_first;
    ctl.div_load = (state == tma_pkg::ST_ADD) && res_done;
    ctl.div_step = (state == tma_pkg::ST_DIV);
    ctl.n        = res_n;
  end

  // Color lanes
  tma_lane u_lane_r (.clk(clk), .ctl(ctl), .pix(pix_red),   .mean(mean_r));
  tma_lane u_lane_g (.clk(clk), .ctl(ctl), .pix(pix_green), .mean(mean_g));
  tma_lane u_lane_b (.clk(clk), .ctl(ctl), .pix(pix_blue),  .mean(mean_b));

  // Merge lane results into the output word
  always_ff @(posedge clk) begin
    if (rst) begin
      tile_valid <= 1'b0;
    end else if (out_load) begin
      tile_valid <= 1'b1;
    end else if (tile_ready) begin
      tile_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      red_mean   <= res_err ? 8'd0 : mean_r;
      green_mean <= res_err ? 8'd0 : mean_g;
      blue_mean  <= res_err ? 8'd0 : mean_b;
      tile_top   <= res_err ? 12'd0 : res_top;
      tile_left  <= res_err ? 12'd0 : res_left;
      tile_rows  <= res_err ? 7'd0 : res_rows;
      tile_cols  <= res_err ? 7'd0 : res_cols;
      size_error <= res_err;
    end
  end

  // Checks
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (tile_valid && size_error) |-> (tile_rows == 7'd0 && tile_cols == 7'd0 &&
                                    red_mean == 8'd0))
    else $error("error word carries nonzero fields");

  a_dims: assert property (@(posedge clk) disable iff (rst)
    (tile_valid && !size_error) |-> (tile_rows != 7'd0 && tile_cols != 7'd0))
    else $error("tile word with empty dimensions");

  a_add: assert property (@(posedge clk) disable iff (rst)
    (pix_acc && !rej) |=> (state == tma_pkg::ST_ADD))
    else $error("accepted pixel of a live frame skipped accumulation");

  a_div_len: assert property (@(posedge clk) disable iff (rst)
    (state == tma_pkg::ST_ADD && res_done) |=> ##8 (state == tma_pkg::ST_EMIT))
    else $error("divider did not finish in eight steps");

endmodule
`default_nettype wire
